[rtl/prc_pkg.sv]
// Shared types and constants of the polygon rectangle clipper.
// No dependencies; every other file of the block but prc_muldiv uses this package.
package prc_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int WIN_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int LEVELS          = 4;
  localparam int BUF_DEPTH       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

  localparam logic [1:0] LVL_LEFT   = 2'd0;
  localparam logic [1:0] LVL_RIGHT  = 2'd1;
  localparam logic [1:0] LVL_TOP    = 2'd2;
  localparam logic [1:0] LVL_BOTTOM = 2'd3;

  typedef struct packed {
    logic signed [WIN_W-1:0] left;
    logic signed [WIN_W-1:0] bottom;
    logic signed [WIN_W-1:0] right;
    logic signed [WIN_W-1:0] top;
  } window_t;

  typedef struct packed {
    logic valid;
    logic final_vertex;
  } queue_head_t;

  // Internal vertex width: wide enough for input coordinates and scaled window edges.
  function automatic int vertex_width(input int cw, input int fb);
    return (cw > WIN_W + fb) ? cw : WIN_W + fb;
  endfunction

endpackage

[rtl/prc_front.sv]
// Input side of the clipper: a two-entry vertex queue that takes requests.
// Depends on prc_pkg.
module prc_front #(
  parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic                          in_final,
  input  logic                          pop,
  output prc_pkg::queue_head_t          head,
  output logic signed [COORD_WIDTH-1:0] head_x,
  output logic signed [COORD_WIDTH-1:0] head_y
);

  logic signed [COORD_WIDTH-1:0] qx_r [2];
  logic signed [COORD_WIDTH-1:0] qy_r [2];
  logic                          qf_r [2];
  logic                          wr_ptr_r;
  logic                          rd_ptr_r;
  logic [1:0]                    cnt_r;
  logic                          push;
  logic                          do_pop;

  assign in_ready          = (cnt_r != 2'd2);
  assign push              = in_valid && in_ready;
  assign do_pop            = pop && (cnt_r != 2'd0);
  assign head.valid        = (cnt_r != 2'd0);
  assign head.final_vertex = qf_r[rd_ptr_r];
  assign head_x            = qx_r[rd_ptr_r];
  assign head_y            = qy_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        qx_r[wr_ptr_r] <= in_x;
        qy_r[wr_ptr_r] <= in_y;
        qf_r[wr_ptr_r] <= in_final;
        wr_ptr_r       <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

[rtl/prc_muldiv.sv]
// Serial unit for trunc(e * n / d) with |n| <= |d|, one bit of e per cycle.
// Depends on prc_pkg only through its callers; used by prc_back.
module prc_muldiv #(
  parameter int DW = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] e,
  input  logic signed [DW-1:0] n,
  input  logic signed [DW-1:0] d,
  output logic                 done,
  output logic signed [DW-1:0] q
);

  localparam int RW = DW + 2;
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    ae_r;
  logic [DW-1:0]    an_r;
  logic [DW-1:0]    ad_r;
  logic [RW-1:0]    rem_r;
  logic [DW-1:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             run_r;
  logic             done_r;
  logic [RW-1:0]    acc;
  logic [RW-1:0]    d1;
  logic [RW-1:0]    d2;
  logic [RW-1:0]    rem_nxt;
  logic [DW-1:0]    quo_nxt;

  always_comb begin
    d1  = {2'b00, ad_r};
    d2  = {1'b0, ad_r, 1'b0};
    acc = {rem_r[RW-2:0], 1'b0} + (ae_r[DW-1] ? {2'b00, an_r} : {RW{1'b0}});
    if (acc >= d2) begin
      rem_nxt = acc - d2;
      quo_nxt = {quo_r[DW-2:0], 1'b0} + DW'(2);
    end else if (acc >= d1) begin
      rem_nxt = acc - d1;
      quo_nxt = {quo_r[DW-2:0], 1'b0} + DW'(1);
    end else begin
      rem_nxt = acc;
      quo_nxt = {quo_r[DW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign q    = neg_r ? -$signed(quo_r) : $signed(quo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        ae_r  <= e[DW-1] ? DW'(-e) : DW'(e);
        an_r  <= n[DW-1] ? DW'(-n) : DW'(n);
        ad_r  <= d[DW-1] ? DW'(-d) : DW'(d);
        neg_r <= e[DW-1] ^ n[DW-1] ^ d[DW-1];
        rem_r <= '0;
        quo_r <= '0;
        cnt_r <= CNT_W'(DW);
        run_r <= 1'b1;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        ae_r  <= {ae_r[DW-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/prc_back.sv]
// Clip engine: left, right, top and bottom edge stages fed through small level buffers, and the output hold stage.
// Depends on prc_pkg and prc_muldiv.
module prc_back #(
  parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = prc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prc_pkg::window_t              win,
  input  prc_pkg::queue_head_t          head,
  input  logic signed [COORD_WIDTH-1:0] head_x,
  input  logic signed [COORD_WIDTH-1:0] head_y,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_WIDTH-1:0]        out_x,
  output logic [COORD_WIDTH-1:0]        out_y,
  output logic                          out_last,
  output logic                          out_empty
);

  localparam int VW = prc_pkg::vertex_width(COORD_WIDTH, FRAC_BITS);
  localparam int DW = VW + 1;

  typedef enum logic [1:0] {ST_PICK, ST_EDGE, ST_DIV} state_t;

  state_t                state_r;
  logic signed [VW-1:0]  fx_r [prc_pkg::LEVELS];
  logic signed [VW-1:0]  fy_r [prc_pkg::LEVELS];
  logic signed [VW-1:0]  px_r [prc_pkg::LEVELS];
  logic signed [VW-1:0]  py_r [prc_pkg::LEVELS];
  logic                  has_r [prc_pkg::LEVELS];
  logic signed [VW-1:0]  bx_r [prc_pkg::LEVELS][prc_pkg::BUF_DEPTH];
  logic signed [VW-1:0]  by_r [prc_pkg::LEVELS][prc_pkg::BUF_DEPTH];
  logic                  bc_r [prc_pkg::LEVELS][prc_pkg::BUF_DEPTH];
  logic [1:0]            bcnt_r [prc_pkg::LEVELS];
  logic [1:0]            brd_r [prc_pkg::LEVELS];
  logic                  close0_r;
  logic [1:0]            lvl_r;
  logic signed [VW-1:0]  p1x_r, p1y_r, p2x_r, p2y_r;
  logic                  edge_r;
  logic                  close_r;
  logic signed [VW-1:0]  hx_r, hy_r;
  logic                  hv_r;
  logic                  out_valid_r;
  logic [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic                  out_last_r, out_empty_r;

  logic                  out_free;
  logic                  sink_go, clip_go;
  logic [1:0]            sel_lvl, src;
  logic signed [VW-1:0]  tok_x, tok_y;
  logic                  tok_cl;
  logic                  pop_buf;
  logic [1:0]            pb;
  logic signed [VW-1:0]  bnd_l, bnd_r, bnd_t, bnd_b, bnd;
  logic signed [VW-1:0]  a1, a2, o1, o2;
  logic                  in1, in2, cross_need;
  logic                  div_start, div_done;
  logic signed [DW-1:0]  div_e, div_n, div_d, div_q, co;
  logic signed [VW-1:0]  cx, cy;
  logic                  wr_go;
  logic [1:0]            wcnt;
  logic signed [VW-1:0]  wx [prc_pkg::BUF_DEPTH];
  logic signed [VW-1:0]  wy [prc_pkg::BUF_DEPTH];
  logic                  wc [prc_pkg::BUF_DEPTH];

  assign bnd_l = VW'($signed(win.left)) <<< FRAC_BITS;
  assign bnd_r = VW'($signed(win.right)) <<< FRAC_BITS;
  assign bnd_t = VW'($signed(win.top)) <<< FRAC_BITS;
  assign bnd_b = VW'($signed(win.bottom)) <<< FRAC_BITS;

  assign out_free = !out_valid_r || out_ready;
  assign sink_go  = (state_r == ST_PICK) && (bcnt_r[3] != 2'd0) && out_free;
  assign clip_go  = (state_r == ST_PICK) && (bcnt_r[3] == 2'd0) &&
                    ((bcnt_r[2] != 2'd0) || (bcnt_r[1] != 2'd0) ||
                     (bcnt_r[0] != 2'd0) || head.valid);

  always_comb begin
    priority if (bcnt_r[2] != 2'd0) sel_lvl = prc_pkg::LVL_BOTTOM;
    else if (bcnt_r[1] != 2'd0)     sel_lvl = prc_pkg::LVL_TOP;
    else if (bcnt_r[0] != 2'd0)     sel_lvl = prc_pkg::LVL_RIGHT;
    else                            sel_lvl = prc_pkg::LVL_LEFT;
    src = sel_lvl - 2'd1;
    if (sel_lvl == prc_pkg::LVL_LEFT) begin
      tok_x  = VW'(head_x);
      tok_y  = VW'(head_y);
      tok_cl = close0_r;
    end else begin
      tok_x  = bx_r[src][brd_r[src]];
      tok_y  = by_r[src][brd_r[src]];
      tok_cl = bc_r[src][brd_r[src]];
    end
  end

  assign pop     = clip_go && (sel_lvl == prc_pkg::LVL_LEFT) &&
                   (close0_r || !head.final_vertex);
  assign pop_buf = sink_go || (clip_go && (sel_lvl != prc_pkg::LVL_LEFT));
  assign pb      = sink_go ? 2'd3 : src;

  always_comb begin
    unique case (lvl_r)
      prc_pkg::LVL_LEFT:   bnd = bnd_l;
      prc_pkg::LVL_RIGHT:  bnd = bnd_r;
      prc_pkg::LVL_TOP:    bnd = bnd_t;
      prc_pkg::LVL_BOTTOM: bnd = bnd_b;
      default:             bnd = bnd_l;
    endcase
    if (lvl_r == prc_pkg::LVL_LEFT || lvl_r == prc_pkg::LVL_RIGHT) begin
      a1 = p1x_r; a2 = p2x_r; o1 = p1y_r; o2 = p2y_r;
    end else begin
      a1 = p1y_r; a2 = p2y_r; o1 = p1x_r; o2 = p2x_r;
    end
    if (lvl_r == prc_pkg::LVL_LEFT || lvl_r == prc_pkg::LVL_BOTTOM) begin
      in1 = (a1 >= bnd);
      in2 = (a2 >= bnd);
    end else begin
      in1 = (a1 <= bnd);
      in2 = (a2 <= bnd);
    end
  end

  assign cross_need = edge_r && (in1 ^ in2);
  assign div_start  = (state_r == ST_EDGE) && cross_need;
  assign div_e      = DW'(o2) - DW'(o1);
  assign div_n      = DW'(a2) - DW'(bnd);
  assign div_d      = DW'(a2) - DW'(a1);
  assign co         = DW'(o2) - div_q;

  always_comb begin
    if (lvl_r == prc_pkg::LVL_LEFT || lvl_r == prc_pkg::LVL_RIGHT) begin
      cx = bnd;
      cy = co[VW-1:0];
    end else begin
      cx = co[VW-1:0];
      cy = bnd;
    end
  end

  prc_muldiv #(.DW(DW)) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .e     (div_e),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  assign wr_go = ((state_r == ST_EDGE) && !cross_need) || ((state_r == ST_DIV) && div_done);

  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < prc_pkg::BUF_DEPTH; i++) begin
      wx[i] = p2x_r;
      wy[i] = p2y_r;
      wc[i] = 1'b0;
    end
    if (state_r == ST_DIV) begin
      wx[k] = cx;
      wy[k] = cy;
      k = k + 2'd1;
      if (in2) begin
        wx[k] = p2x_r;
        wy[k] = p2y_r;
        k = k + 2'd1;
      end
    end else if (edge_r && in1 && in2) begin
      k = k + 2'd1;
    end
    if (close_r) begin
      wc[k] = 1'b1;
      k = k + 2'd1;
    end
    wcnt = k;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_PICK;
      has_r       <= '{default: 1'b0};
      bcnt_r      <= '{default: 2'd0};
      brd_r       <= '{default: 2'd0};
      close0_r    <= 1'b0;
      hv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      lvl_r       <= prc_pkg::LVL_LEFT;
      edge_r      <= 1'b0;
      close_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_PICK: begin
          if (sink_go) begin
            if (bc_r[3][brd_r[3]]) begin
              out_valid_r <= 1'b1;
              out_x_r     <= hv_r ? hx_r[COORD_WIDTH-1:0] : '0;
              out_y_r     <= hv_r ? hy_r[COORD_WIDTH-1:0] : '0;
              out_last_r  <= 1'b1;
              out_empty_r <= !hv_r;
              hv_r        <= 1'b0;
            end else begin
              if (hv_r) begin
                out_valid_r <= 1'b1;
                out_x_r     <= hx_r[COORD_WIDTH-1:0];
                out_y_r     <= hy_r[COORD_WIDTH-1:0];
                out_last_r  <= 1'b0;
                out_empty_r <= 1'b0;
              end
              hx_r <= bx_r[3][brd_r[3]];
              hy_r <= by_r[3][brd_r[3]];
              hv_r <= 1'b1;
            end
          end else if (clip_go) begin
            lvl_r   <= sel_lvl;
            close_r <= tok_cl;
            if (tok_cl) begin
              edge_r         <= has_r[sel_lvl];
              p1x_r          <= px_r[sel_lvl];
              p1y_r          <= py_r[sel_lvl];
              p2x_r          <= fx_r[sel_lvl];
              p2y_r          <= fy_r[sel_lvl];
              has_r[sel_lvl] <= 1'b0;
            end else if (!has_r[sel_lvl]) begin
              fx_r[sel_lvl]  <= tok_x;
              fy_r[sel_lvl]  <= tok_y;
              px_r[sel_lvl]  <= tok_x;
              py_r[sel_lvl]  <= tok_y;
              has_r[sel_lvl] <= 1'b1;
              edge_r         <= 1'b0;
            end else begin
              p1x_r         <= px_r[sel_lvl];
              p1y_r         <= py_r[sel_lvl];
              p2x_r         <= tok_x;
              p2y_r         <= tok_y;
              px_r[sel_lvl] <= tok_x;
              py_r[sel_lvl] <= tok_y;
              edge_r        <= 1'b1;
            end
            if (sel_lvl == prc_pkg::LVL_LEFT) begin
              close0_r <= !close0_r && head.final_vertex;
            end
            state_r <= ST_EDGE;
          end
        end
        ST_EDGE: begin
          state_r <= cross_need ? ST_DIV : ST_PICK;
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_PICK;
          end
        end
        default: state_r <= ST_PICK;
      endcase
      if (pop_buf) begin
        if (2'(brd_r[pb] + 2'd1) == bcnt_r[pb]) begin
          bcnt_r[pb] <= 2'd0;
          brd_r[pb]  <= 2'd0;
        end else begin
          brd_r[pb] <= brd_r[pb] + 2'd1;
        end
      end
      if (wr_go) begin
        for (int i = 0; i < prc_pkg::BUF_DEPTH; i++) begin
          bx_r[lvl_r][i] <= wx[i];
          by_r[lvl_r][i] <= wy[i];
          bc_r[lvl_r][i] <= wc[i];
        end
        bcnt_r[lvl_r] <= wcnt;
        brd_r[lvl_r]  <= 2'd0;
      end
    end
  end

endmodule

[rtl/polygon_rect_clipper.sv]
// Top level of the polygon rectangle clipper: window registers, input queue and clip engine.
// Depends on prc_pkg, prc_front and prc_back.
//
// Vertices arrive as requests on the in_ channel, x and y in tdata, tlast on the last
// vertex of a polygon. Clipped vertices leave on the out_ channel in the same format;
// out_tlast marks the final vertex of a polygon, and out_tuser marks a polygon that was
// clipped away completely, sent as one request with zero coordinates.
// The window registers (left, bottom, right, top, whole units) are written on the cfg_
// port; the user must write them only while no polygon is in flight, and the block
// itself does not enforce this. Reset sets them to zero. A vertex token passes the PICK
// and EDGE states in each of the edge stages that it reaches and then the output hold
// stage, and every intersection adds a run of the serial multiply-divide unit.
// One result is held back inside, so results of a polygon leave one vertex late and the
// rest on its last vertex. A two-entry input queue lets the sender run ahead; when the
// receiver stalls, the engine stops once its output register is full and a result
// waits in the bottom stage buffer. Synchronous active-low reset clears the queue, the
// stage valid flags and buffer counts, the held result flag and the output valid flag.
module polygon_rect_clipper #(
  parameter int COORD_WIDTH = prc_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = prc_pkg::FRAC_BITS_DEF,
  localparam int TDW = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [TDW-1:0]                in_tdata,   // vertex_x, vertex_y
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [TDW-1:0]                out_tdata,  // out_x, out_y
  output logic                          out_tlast,
  output logic                          out_tuser,  // polygon_empty
  input  logic                          cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prc_pkg::WIN_W-1:0]     cfg_wdata
);

  prc_pkg::window_t              win_r;
  prc_pkg::queue_head_t          head;
  logic signed [COORD_WIDTH-1:0] head_x, head_y;
  logic                          pop;
  logic [COORD_WIDTH-1:0]        res_x, res_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prc_pkg::REG_LEFT:   win_r.left   <= cfg_wdata;
        prc_pkg::REG_BOTTOM: win_r.bottom <= cfg_wdata;
        prc_pkg::REG_RIGHT:  win_r.right  <= cfg_wdata;
        prc_pkg::REG_TOP:    win_r.top    <= cfg_wdata;
        default:             win_r        <= win_r;
      endcase
    end
  end

  prc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_x     (in_tdata[COORD_WIDTH-1:0]),
    .in_y     (in_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .in_final (in_tlast),
    .pop      (pop),
    .head     (head),
    .head_x   (head_x),
    .head_y   (head_y)
  );

  prc_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .head      (head),
    .head_x    (head_x),
    .head_y    (head_y),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_last  (out_tlast),
    .out_empty (out_tuser)
  );

  assign out_tdata = TDW'({res_y, res_x});

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("empty polygon request without last flag");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("empty polygon request with nonzero coordinates");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output request right after reset");

endmodule

[tb/polygon_rect_clipper_tb.sv]
// Self-checking testbench for polygon_rect_clipper: streams polygons through the
// clip window and checks each clipped vertex against an in-bench clip predictor.
// Depends on prc_pkg and the polygon_rect_clipper RTL.
`timescale 1ns / 100ps

module polygon_rect_clipper_tb;

  localparam int CW = prc_pkg::COORD_WIDTH_DEF;
  localparam int FB = prc_pkg::FRAC_BITS_DEF;
  localparam int TDW = ((2 * CW + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1500;
  localparam int MAX_PER_VERTEX = 16;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } vertex_req_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
    logic                 empty;
  } clipped_vertex_t;

  typedef struct {
    longint x;
    longint y;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [prc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [prc_pkg::WIN_W-1:0] cfg_wdata = '0;

  vertex_req_t pending_vertices[$];
  clipped_vertex_t expected_vertices[$];
  point_t stage_out[$];
  vertex_req_t drv_item;

  logic signed [prc_pkg::WIN_W-1:0] win_left = '0, win_bottom = '0, win_right = '0, win_top = '0;
  point_t stage_first[4];
  point_t stage_prev[4];
  bit stage_has_first[4];
  point_t held_vertex;
  bit held_valid = 1'b0;
  int emitted_count;

  int idle_pct = 0;
  int stall_pct = 0;
  bit long_stall_req = 1'b0;
  bit long_stall_taken = 1'b0;
  int stall_left = 0;
  int error_count = 0;
  int quiet_cycles = 0;

  polygon_rect_clipper u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic longint edge_bound(logic [1:0] lvl);
    logic signed [prc_pkg::WIN_W-1:0] raw;
    case (lvl)
      prc_pkg::LVL_LEFT:  raw = win_left;
      prc_pkg::LVL_RIGHT: raw = win_right;
      prc_pkg::LVL_TOP:   raw = win_top;
      default:            raw = win_bottom;
    endcase
    return longint'(raw) * (64'sd1 <<< FB);
  endfunction

  function automatic bit is_inside(logic [1:0] lvl, point_t p);
    longint a;
    a = (lvl == prc_pkg::LVL_LEFT || lvl == prc_pkg::LVL_RIGHT) ? p.x : p.y;
    if (lvl == prc_pkg::LVL_LEFT || lvl == prc_pkg::LVL_BOTTOM) return a >= edge_bound(lvl);
    return a <= edge_bound(lvl);
  endfunction

  function automatic longint scaled_quotient(longint e, longint n, longint d);
    if (d == 0) return 0;
    return (e * n) / d;
  endfunction

  function automatic point_t crossing(logic [1:0] lvl, point_t p1, point_t p2);
    point_t r;
    longint w;
    w = edge_bound(lvl);
    if (lvl == prc_pkg::LVL_LEFT || lvl == prc_pkg::LVL_RIGHT) begin
      r.x = w;
      r.y = p2.y - scaled_quotient(p2.y - p1.y, p2.x - w, p2.x - p1.x);
    end else begin
      r.y = w;
      r.x = p2.x - scaled_quotient(p2.x - p1.x, p2.y - w, p2.y - p1.y);
    end
    return r;
  endfunction

  function automatic void clip_edge(logic [1:0] lvl, point_t p1, point_t p2);
    bit in1, in2;
    in1 = is_inside(lvl, p1);
    in2 = is_inside(lvl, p2);
    if (in1 && in2) begin
      stage_out = {stage_out, p2};
    end else if (in1) begin
      stage_out = {stage_out, crossing(lvl, p1, p2)};
    end else if (in2) begin
      stage_out = {stage_out, crossing(lvl, p1, p2)};
      stage_out = {stage_out, p2};
    end
  endfunction

  function automatic void emit_vertex(longint x, longint y, logic last, logic empty);
    clipped_vertex_t c;
    if (emitted_count >= MAX_PER_VERTEX) return;
    c.x = x[CW-1:0];
    c.y = y[CW-1:0];
    c.last = last;
    c.empty = empty;
    expected_vertices = {expected_vertices, c};
    emitted_count++;
  endfunction

  // Each stage is run over its whole input list before the next one; this keeps
  // the vertex order of the depth-first cascade.
  function automatic void predict_clip(vertex_req_t v);
    point_t cur[$];
    point_t p;
    point_t p1;
    logic [1:0] lvl;
    emitted_count = 0;
    p.x = longint'(v.x);
    p.y = longint'(v.y);
    cur = {cur, p};
    for (int s = 0; s < 4; s++) begin
      lvl = s[1:0];
      stage_out.delete();
      foreach (cur[i]) begin
        if (!stage_has_first[s]) begin
          stage_first[s] = cur[i];
          stage_prev[s] = cur[i];
          stage_has_first[s] = 1'b1;
        end else begin
          p1 = stage_prev[s];
          stage_prev[s] = cur[i];
          clip_edge(lvl, p1, cur[i]);
        end
      end
      if (v.last && stage_has_first[s]) begin
        stage_has_first[s] = 1'b0;
        clip_edge(lvl, stage_prev[s], stage_first[s]);
      end
      cur = stage_out;
    end
    foreach (cur[i]) begin
      if (held_valid) emit_vertex(held_vertex.x, held_vertex.y, 1'b0, 1'b0);
      held_vertex = cur[i];
      held_valid = 1'b1;
    end
    if (v.last) begin
      if (held_valid) begin
        emit_vertex(held_vertex.x, held_vertex.y, 1'b1, 1'b0);
        held_valid = 1'b0;
      end else begin
        emit_vertex(0, 0, 1'b1, 1'b1);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        drv_item.x = in_tdata[CW-1:0];
        drv_item.y = in_tdata[2*CW-1:CW];
        drv_item.last = in_tlast;
        predict_clip(drv_item);
      end
      if (!in_tvalid || in_tready) begin
        if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct) begin
          drv_item = pending_vertices.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= TDW'({drv_item.y, drv_item.x});
          in_tlast <= drv_item.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_stall_req && !long_stall_taken) begin
      long_stall_taken <= 1'b1;
      stall_left <= 600;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    clipped_vertex_t exp_v;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_vertices.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d last=%0b empty=%0b", $time,
                 $signed(out_tdata[CW-1:0]), $signed(out_tdata[2*CW-1:CW]),
                 out_tlast, out_tuser);
        error_count <= error_count + 1;
      end else begin
        exp_v = expected_vertices.pop_front();
        if (out_tdata[CW-1:0] !== exp_v.x || out_tdata[2*CW-1:CW] !== exp_v.y ||
            out_tlast !== exp_v.last || out_tuser !== exp_v.empty) begin
          $display("%0t: mismatch expected x=%0d y=%0d last=%0b empty=%0b, got x=%0d y=%0d last=%0b empty=%0b",
                   $time, exp_v.x, exp_v.y, exp_v.last, exp_v.empty,
                   $signed(out_tdata[CW-1:0]), $signed(out_tdata[2*CW-1:CW]),
                   out_tlast, out_tuser);
          error_count <= error_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("polygon_rect_clipper regression: fail");
        $finish;
      end
    end
  end

  task automatic write_window(int l, int b, int r, int t);
    logic signed [prc_pkg::WIN_W-1:0] vals[4];
    logic [prc_pkg::CFG_IDX_W-1:0] idx[4];
    vals = '{l[prc_pkg::WIN_W-1:0], b[prc_pkg::WIN_W-1:0], r[prc_pkg::WIN_W-1:0],
             t[prc_pkg::WIN_W-1:0]};
    idx = '{prc_pkg::REG_LEFT, prc_pkg::REG_BOTTOM, prc_pkg::REG_RIGHT, prc_pkg::REG_TOP};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    win_left = vals[0];
    win_bottom = vals[1];
    win_right = vals[2];
    win_top = vals[3];
  endtask

  task automatic add_vertex(longint x, longint y, bit last);
    vertex_req_t v;
    v.x = x[CW-1:0];
    v.y = y[CW-1:0];
    v.last = last;
    pending_vertices = {pending_vertices, v};
  endtask

  task automatic drain();
    while (pending_vertices.size() != 0 || in_tvalid || expected_vertices.size() != 0)
      @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  function automatic longint random_coord(int lo_u, int hi_u);
    longint lo, hi, v;
    if ($urandom_range(9) == 0) return longint'($signed(24'($urandom)));
    lo = (lo_u < hi_u) ? lo_u : hi_u;
    hi = (lo_u < hi_u) ? hi_u : lo_u;
    lo = (lo - 16) * 256;
    hi = (hi + 16) * 256;
    v = lo + longint'($urandom_range(32'(hi - lo)));
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v;
  endfunction

  task automatic random_polygons(int count);
    int n;
    while (count > 0) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++)
        add_vertex(random_coord(win_left, win_right), random_coord(win_bottom, win_top),
                   i == n - 1);
      count -= n;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_window(-10, -10, 10, 10);
    add_vertex(0, 0, 1);
    add_vertex(50 * 256, 0, 1);
    add_vertex(0, 0, 0);
    add_vertex(50 * 256, 5 * 256 + 77, 1);
    add_vertex(-20 * 256, -20 * 256, 0);
    add_vertex(20 * 256, -20 * 256, 0);
    add_vertex(20 * 256, 20 * 256, 0);
    add_vertex(-20 * 256, 20 * 256, 1);
    add_vertex(-10 * 256, -10 * 256, 0);
    add_vertex(10 * 256, -10 * 256, 0);
    add_vertex(10 * 256, 10 * 256, 1);
    add_vertex(-8388608, -8388608, 0);
    add_vertex(8388607, -8388608, 0);
    add_vertex(8388607, 8388607, 0);
    add_vertex(-8388608, 8388607, 1);
    add_vertex(30 * 256, 30 * 256, 0);
    add_vertex(40 * 256, 30 * 256, 0);
    add_vertex(35 * 256, 40 * 256, 1);
    drain();

    // The receiver holds off for a long stretch so that the input side backs up.
    write_window(-100, -80, 100, 80);
    idle_pct = 0;
    stall_pct = 0;
    long_stall_req = 1'b1;
    random_polygons(75);
    drain();

    write_window(-32768, -32768, 32767, 32767);
    idle_pct = 54;
    stall_pct = 0;
    random_polygons(60);
    drain();

    write_window(1000, 2000, 1300, 2100);
    idle_pct = 0;
    stall_pct = 54;
    random_polygons(75);
    drain();

    write_window(50, -10, -50, 10);
    idle_pct = 15;
    stall_pct = 15;
    random_polygons(45);
    drain();

    write_window(-32768, 32767, -32768, 32767);
    random_polygons(30);
    drain();

    write_window(-5, -300, 5, 300);
    idle_pct = 54;
    stall_pct = 54;
    random_polygons(75);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_vertices.size() == 0) begin
      $display("polygon_rect_clipper regression: pass");
    end else begin
      $display("polygon_rect_clipper regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/prc_pkg.sv
rtl/prc_front.sv
rtl/prc_muldiv.sv
rtl/prc_back.sv
rtl/polygon_rect_clipper.sv
tb/polygon_rect_clipper_tb.sv
